// ===== rtl/core/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants, codes and item types of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);

  // field widths
  localparam int OP_W   = 2;
  localparam int CODE_W = 8;
  localparam int CLR_W  = 4;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;

  // blank cell: white on black space
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // control characters
  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam int                TAB_STOP = 8;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CODE_W-1:0] char_code;
    logic [CLR_W-1:0]  bg_color;
    logic [CLR_W-1:0]  fg_color;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_column;
  } tcce_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [LOC_W-1:0]  cursor_location;
    logic [CELL_W-1:0] cell_data;
  } tcce_out_t;

endpackage

// ===== rtl/core/tcce_in_if.sv =====
// ----------------------------------------------------------------------------
// tcce_in_if
// Valid/ready channel that carries command items into the console engine.
// ----------------------------------------------------------------------------
interface tcce_in_if;
  logic               valid;
  logic               ready;
  tcce_pkg::tcce_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tcce_out_if.sv =====
// ----------------------------------------------------------------------------
// tcce_out_if
// Valid/ready channel that carries result items out of the console engine.
// ----------------------------------------------------------------------------
interface tcce_out_if;
  logic                valid;
  logic                ready;
  tcce_pkg::tcce_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/text_console_char_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_char_engine
// 80x25 text console: cell store, cursor, put/clear/read command items.
// ----------------------------------------------------------------------------
// The screen lives in one RAM of 16-bit cells (attribute in the high byte).
// A put that does not scroll, a read outside the screen and an unused
// operation load the result register as they are accepted, so such items
// go at one per cycle while the result channel is free. An in-range read
// goes through the registered RAM read, RDWAIT and FINISH, which loads the
// result. A put that scrolls copies every row up through the single RAM
// port pair, one cell per cycle, then blanks the bottom row. A clear writes
// every cell. After reset a clearing pass blanks the store, and no item is
// taken until it finishes.
module text_console_char_engine (
  input  logic              clk,
  input  logic              rst_n,
  tcce_in_if.sink           in_chan,
  tcce_out_if.source        out_chan
);

  localparam int ADDR_W = tcce_pkg::ADDR_W;
  localparam int ROW_W  = tcce_pkg::ROW_W;
  localparam int COL_W  = tcce_pkg::COL_W;
  localparam int LOC_W  = tcce_pkg::LOC_W;
  localparam int CELL_W = tcce_pkg::CELL_W;

  // sequencer states
  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RDWAIT = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_BLANK  = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(tcce_pkg::CELLS - 1);
  localparam logic [ADDR_W-1:0] MOVE_END  = ADDR_W'(tcce_pkg::MOVE_CELLS);

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [ROW_W-1:0]    cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [CELL_W-1:0]   cell_r, cell_nxt;
  logic                out_valid_r, out_valid_nxt;
  tcce_pkg::tcce_out_t out_data_r, out_data_nxt;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata;

  logic                out_free, accept;
  tcce_pkg::tcce_in_t  item;

  // put character: next cursor
  logic [COL_W:0]      colx;
  logic [ROW_W:0]      rowx;
  logic                put_we, put_scroll;
  logic [ADDR_W-1:0]   cur_addr, rd_addr;
  logic                rd_in_range;

  // result load
  logic                load_out;
  logic [ROW_W-1:0]    lo_row;
  logic [COL_W-1:0]    lo_col;
  logic [CELL_W-1:0]   lo_cell;

  assign item     = in_chan.data;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_chan.valid && in_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // cell addresses
  assign cur_addr = ADDR_W'(cur_row_r) * ADDR_W'(tcce_pkg::COLUMNS) + ADDR_W'(cur_col_r);
  assign rd_addr  = ADDR_W'(item.read_row) * ADDR_W'(tcce_pkg::COLUMNS)
                    + ADDR_W'(item.read_column);
  assign rd_in_range = (item.read_row < ROW_W'(tcce_pkg::ROWS)) &&
                       (item.read_column < COL_W'(tcce_pkg::COLUMNS));

  // cursor movement of a put
  always_comb begin
    colx   = {1'b0, cur_col_r};
    rowx   = {1'b0, cur_row_r};
    put_we = 1'b0;
    if (item.char_code == tcce_pkg::CH_BS && cur_col_r != '0) begin
      colx = colx - 1'b1;
    end else if (item.char_code == tcce_pkg::CH_TAB) begin
      colx = (colx + (COL_W+1)'(tcce_pkg::TAB_STOP))
             & ~((COL_W+1)'(tcce_pkg::TAB_STOP - 1));
    end else if (item.char_code == tcce_pkg::CH_CR) begin
      colx = '0;
    end else if (item.char_code == tcce_pkg::CH_LF) begin
      colx = '0;
      rowx = rowx + 1'b1;
    end else if (item.char_code >= tcce_pkg::CH_SPACE && !item.char_code[7]) begin
      put_we = 1'b1;
      colx   = colx + 1'b1;
    end
    // wrap at the right edge
    if (colx >= (COL_W+1)'(tcce_pkg::COLUMNS)) begin
      colx = '0;
      rowx = rowx + 1'b1;
    end
    // past the bottom row
    put_scroll = (rowx >= (ROW_W+1)'(tcce_pkg::ROWS));
    if (put_scroll) begin
      rowx = (ROW_W+1)'(tcce_pkg::ROWS - 1);
    end
  end

  // sequencer and RAM control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    cell_nxt      = cell_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = tcce_pkg::BLANK_CELL;
    ram_re        = 1'b0;
    ram_raddr     = cnt_r;
    load_out      = 1'b0;
    lo_row        = cur_row_r;
    lo_col        = cur_col_r;
    lo_cell       = '0;

    case (state_r)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (item.operation)
            tcce_pkg::OP_PUT: begin
              ram_we      = put_we;
              ram_waddr   = cur_addr;
              ram_wdata   = {item.bg_color, item.fg_color, item.char_code};
              cur_row_nxt = rowx[ROW_W-1:0];
              cur_col_nxt = colx[COL_W-1:0];
              cell_nxt    = '0;
              if (put_scroll) begin
                cnt_nxt   = '0;
                state_nxt = ST_SCROLL;
              end else begin
                load_out = 1'b1;
                lo_row   = rowx[ROW_W-1:0];
                lo_col   = colx[COL_W-1:0];
              end
            end
            tcce_pkg::OP_CLEAR: begin
              cur_row_nxt = '0;
              cur_col_nxt = '0;
              cell_nxt    = '0;
              cnt_nxt     = '0;
              state_nxt   = ST_CLEAR;
            end
            tcce_pkg::OP_READ: begin
              if (rd_in_range) begin
                ram_re    = 1'b1;
                ram_raddr = rd_addr;
                state_nxt = ST_RDWAIT;
              end else begin
                load_out = 1'b1;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        cell_nxt  = ram_rdata;
        state_nxt = ST_FINISH;
      end
      ST_SCROLL: begin
        // read one row ahead, write the cell read in the previous cycle
        if (cnt_r != MOVE_END) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r + ADDR_W'(tcce_pkg::COLUMNS);
        end
        if (cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (cnt_r == MOVE_END) begin
          state_nxt = ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_BLANK: begin
        ram_we = 1'b1;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load_out  = 1'b1;
          lo_cell   = cell_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // result register load
    out_data_nxt = out_data_r;
    if (load_out) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.cursor_row      = lo_row;
      out_data_nxt.cursor_column   = lo_col;
      out_data_nxt.cursor_location = LOC_W'(lo_row) * LOC_W'(tcce_pkg::COLUMNS)
                                     + LOC_W'(lo_col);
      out_data_nxt.cell_data       = lo_cell;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

  // cell store
  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (tcce_pkg::CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 80x25 text console engine. A directed table
// covers the field extremes, every control character, ignored codes, the
// unused operation, out-of-range reads and clear. Random put/read/clear
// traffic follows, enough to wrap lines and scroll the screen many times.
// A shadow screen and cursor predict every result item, and the bench
// compares each result item field by field against the oldest prediction.
// Both channels idle at random. The receiver holds off once for a long
// stretch, and the sender drains the engine once.
// ----------------------------------------------------------------------------
module tb;
  import tcce_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [CODE_W-1:0] PRINT_LAST  = 8'h7F;
  localparam int RANDOM_ITEMS = 1380;
  localparam int DRAIN_AT     = 900;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 40;
  localparam int QUIET_LIMIT  = 12000;

  typedef struct {
    tcce_in_t  cmd;
    bit        pinned;
    tcce_out_t report;
  } script_row_t;

  typedef struct {
    bit        pinned;
    tcce_out_t report;
  } pinned_report_t;

  logic clk = 1'b0;
  logic rst_n;

  tcce_in_if  in_ch ();
  tcce_out_if out_ch ();

  text_console_char_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // shadow of the screen store and cursor
  logic [CELL_W-1:0] shadow_cells [CELLS];
  int unsigned cur_row;
  int unsigned cur_col;

  tcce_out_t      due_reports [$];
  pinned_report_t pinned_q [$];

  int items_sent;
  int results_checked;
  int fault_count;
  int quiet_cycles;
  int scroll_total;
  int wrap_total;
  int clear_total;
  int cell_reads;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = BLANK_CELL;
  endfunction

  // advance the shadow console by one command item, return its result item
  function automatic tcce_out_t console_step(tcce_in_t c);
    tcce_out_t rep;
    logic [CELL_W-1:0] peek;
    peek = '0;
    case (c.operation)
      OP_PUT: begin
        if (c.char_code == CH_BS && cur_col != 0) begin
          cur_col--;
        end else if (c.char_code == CH_TAB) begin
          cur_col = (cur_col + TAB_STOP) / TAB_STOP * TAB_STOP;
        end else if (c.char_code == CH_CR) begin
          cur_col = 0;
        end else if (c.char_code == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (c.char_code >= CH_SPACE && c.char_code <= PRINT_LAST) begin
          shadow_cells[cur_row * COLUMNS + cur_col] =
            {c.bg_color, c.fg_color, c.char_code};
          cur_col++;
        end
        // wrap at the right edge
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
          wrap_total++;
        end
        // scroll up one row past the bottom
        if (cur_row >= ROWS) begin
          for (int i = 0; i < MOVE_CELLS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
          for (int i = MOVE_CELLS; i < CELLS; i++) shadow_cells[i] = BLANK_CELL;
          cur_row = ROWS - 1;
          scroll_total++;
        end
      end
      OP_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
        clear_total++;
      end
      OP_READ: begin
        if (c.read_row < ROWS && c.read_column < COLUMNS) begin
          peek = shadow_cells[c.read_row * COLUMNS + c.read_column];
          cell_reads++;
        end
      end
      default: ;
    endcase
    rep.cursor_row      = ROW_W'(cur_row);
    rep.cursor_column   = COL_W'(cur_col);
    rep.cursor_location = LOC_W'(cur_row * COLUMNS + cur_col);
    rep.cell_data       = peek;
    return rep;
  endfunction

  function automatic tcce_in_t make_cmd(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                                        logic [CLR_W-1:0] back, logic [CLR_W-1:0] fore,
                                        logic [ROW_W-1:0] rrow, logic [COL_W-1:0] rcol);
    tcce_in_t c;
    c.operation   = op;
    c.char_code   = code;
    c.bg_color    = back;
    c.fg_color    = fore;
    c.read_row    = rrow;
    c.read_column = rcol;
    return c;
  endfunction

  function automatic tcce_out_t make_report(int row, int col, logic [CELL_W-1:0] peek);
    tcce_out_t r;
    r.cursor_row      = ROW_W'(row);
    r.cursor_column   = COL_W'(col);
    r.cursor_location = LOC_W'(row * COLUMNS + col);
    r.cell_data       = peek;
    return r;
  endfunction

  // mostly text with control characters, reads near the cursor, rare clears
  function automatic tcce_in_t random_cmd();
    tcce_in_t c;
    int pick;
    c.operation   = OP_PUT;
    c.char_code   = CODE_W'($urandom_range(0, 255));
    c.bg_color    = CLR_W'($urandom_range(0, 15));
    c.fg_color    = CLR_W'($urandom_range(0, 15));
    c.read_row    = ROW_W'($urandom_range(0, 31));
    c.read_column = COL_W'($urandom_range(0, 127));
    pick = $urandom_range(0, 999);
    if (pick < 3) begin
      c.operation = OP_CLEAR;
    end else if (pick < 13) begin
      c.operation = OP_UNUSED;
    end else if (pick < 263) begin
      c.operation = OP_READ;
      if (pick < 140) begin
        c.read_row    = ROW_W'(cur_row);
        c.read_column = COL_W'($urandom_range(0, COLUMNS - 1));
      end else if (pick < 238) begin
        c.read_row    = ROW_W'($urandom_range(0, ROWS - 1));
        c.read_column = COL_W'($urandom_range(0, COLUMNS - 1));
      end
    end else if (pick < 343) begin
      c.char_code = CH_LF;
    end else if (pick < 373) begin
      c.char_code = CH_TAB;
    end else if (pick < 393) begin
      c.char_code = CH_CR;
    end else if (pick < 423) begin
      c.char_code = CH_BS;
    end else if (pick >= 463) begin
      c.char_code = CODE_W'($urandom_range(CH_SPACE, PRINT_LAST));
    end
    return c;
  endfunction

  // idle cycles per item, with a stretch of no idling every fourth period
  function automatic int idle_cycles(int n, int period);
    if ((n / period) % 4 == 3) return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, name, want, want, got, got);
      fault_count++;
    end
  endtask

  // offer one command item and wait until it is taken
  task automatic offer(tcce_in_t c, bit pinned, tcce_out_t report);
    int gap;
    gap = idle_cycles(items_sent, 64);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pinned_q.push_back('{pinned, report});
    in_ch.data  <= c;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // predict on each accepted command item, check each accepted result item
  always @(posedge clk) begin : track
    pinned_report_t pin;
    tcce_out_t      want;
    tcce_out_t      got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pin  = pinned_q.pop_front();
        want = console_step(in_ch.data);
        due_reports.push_back(pin.pinned ? pin.report : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (due_reports.size() == 0) begin
          $display("%0t: result item with none expected, got row %0d col %0d cell 0x%0h",
                   $time, got.cursor_row, got.cursor_column, got.cell_data);
          fault_count++;
        end else begin
          want = due_reports.pop_front();
          check_field("cursor_row", want.cursor_row, got.cursor_row);
          check_field("cursor_column", want.cursor_column, got.cursor_column);
          check_field("cursor_location", want.cursor_location, got.cursor_location);
          check_field("cell_data", want.cell_data, got.cell_data);
        end
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin : drain
    int stall;
    int taken;
    out_ch.ready <= 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_cycles(taken, 80);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
    end
  end

  // reset, directed table, random traffic, end of run
  initial begin : feed
    script_row_t script [$];
    tcce_out_t   none;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    none = '0;
    items_sent = 0;
    results_checked = 0;
    fault_count = 0;
    scroll_total = 0;
    wrap_total = 0;
    clear_total = 0;
    cell_reads = 0;
    cur_row = 0;
    cur_col = 0;
    blank_screen();

    script = '{
      // blank screen after reset, corners and out-of-range reads
      '{make_cmd(OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0), 1'b1, make_report(0, 0, BLANK_CELL)},
      '{make_cmd(OP_READ, 8'hFF, 4'hF, 4'hF, 5'd24, 7'd79), 1'b1,
        make_report(0, 0, BLANK_CELL)},
      '{make_cmd(OP_READ, 8'h00, 4'h0, 4'h0, 5'd31, 7'd127), 1'b1, make_report(0, 0, '0)},
      '{make_cmd(OP_READ, 8'h00, 4'h0, 4'h0, 5'd25, 7'd0), 1'b1, make_report(0, 0, '0)},
      '{make_cmd(OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd80), 1'b1, make_report(0, 0, '0)},
      // unused operation, backspace at column zero
      '{make_cmd(OP_UNUSED, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127), 1'b1, make_report(0, 0, '0)},
      '{make_cmd(OP_PUT, CH_BS, 4'h0, 4'h0, 5'd0, 7'd0), 1'b1, make_report(0, 0, '0)},
      // printable extremes and ignored codes
      '{make_cmd(OP_PUT, 8'h41, 4'hF, 4'h0, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_PUT, PRINT_LAST, 4'h0, 4'hF, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_PUT, CH_SPACE, 4'h5, 4'hA, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_PUT, 8'h80, 4'hF, 4'hF, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_PUT, 8'hFF, 4'hF, 4'hF, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_PUT, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_PUT, 8'h1F, 4'h3, 4'hC, 5'd0, 7'd0), 1'b0, none},
      // cursor control characters
      '{make_cmd(OP_PUT, CH_BS, 4'h0, 4'h0, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_PUT, CH_TAB, 4'h0, 4'h0, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_PUT, CH_TAB, 4'h0, 4'h0, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_PUT, CH_CR, 4'h0, 4'h0, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_PUT, CH_LF, 4'h0, 4'h0, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0), 1'b0, none},
      '{make_cmd(OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd1), 1'b0, none},
      // clear homes the cursor and blanks the store
      '{make_cmd(OP_CLEAR, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127), 1'b1, make_report(0, 0, '0)},
      '{make_cmd(OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0), 1'b1, make_report(0, 0, BLANK_CELL)}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) offer(script[i].cmd, script[i].pinned, script[i].report);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // once, let the engine drain before going on
      if (n == DRAIN_AT) begin
        in_ch.valid <= 1'b0;
        wait (results_checked == items_sent);
      end
      offer(random_cmd(), 1'b0, none);
    end
    in_ch.valid <= 1'b0;

    wait (results_checked == items_sent);
    repeat (SETTLE) @(posedge clk);
    if (due_reports.size() != 0) begin
      $display("%0t: %0d expected result items never arrived", $time, due_reports.size());
      fault_count++;
    end

    $display("covered %0d command items, %0d result items, %0d in-range reads",
             items_sent, results_checked, cell_reads);
    $display("screen scrolled %0d times, %0d line wraps, %0d clears, %0d faults",
             scroll_total, wrap_total, clear_total, fault_count);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
